// File: design/spmfd_pkg.sv
package spmfd_pkg;

    // Field widths fixed by the command format
    localparam int HANDLE_W = 8;
    localparam int LEVEL_W  = 4;

    // Defaults for the top-level parameters
    localparam int LEVELS_DEF     = 16;
    localparam int TASK_SLOTS_DEF = 256;

    // Command queue depth between the front and the back
    localparam int QUEUE_DEPTH = 2;

    // Command codes on the request channel
    localparam logic CMD_ENQUEUE  = 1'b0;
    localparam logic CMD_DISPATCH = 1'b1;

    // Classified operation carried through the command queue
    localparam logic [1:0] OP_NOP  = 2'd0;
    localparam logic [1:0] OP_ENQ  = 2'd1;
    localparam logic [1:0] OP_DISP = 2'd2;

    typedef struct packed {
        logic                cmd;
        logic [HANDLE_W-1:0] task_handle;
        logic [LEVEL_W-1:0]  priority_level;
    } req_t;

    typedef struct packed {
        logic                found;
        logic [HANDLE_W-1:0] out_handle;
    } rsp_t;

    typedef struct packed {
        logic [1:0]          op;
        logic [HANDLE_W-1:0] handle;
        logic [LEVEL_W-1:0]  level;
    } entry_t;

endpackage

// File: design/spmfd_front.sv
module spmfd_front #(
    parameter int LEVELS     = spmfd_pkg::LEVELS_DEF,
    parameter int TASK_SLOTS = spmfd_pkg::TASK_SLOTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  spmfd_pkg::req_t     req,
    output logic                q_valid,
    output spmfd_pkg::entry_t   q_entry,
    input  logic                q_pop
);
    import spmfd_pkg::*;

    localparam int QD = QUEUE_DEPTH;
    localparam int PW = (QD > 1) ? $clog2(QD) : 1;
    localparam int CW = $clog2(QD + 1);

    entry_t         entry_in;
    entry_t         q_reg [QD];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic           push;

    // Classify: out-of-range enqueues become no-ops that still answer.
    always_comb
    begin
        entry_in.handle = req.task_handle;
        entry_in.level  = req.priority_level;
        if (req.cmd == CMD_DISPATCH)
        begin
            entry_in.op = OP_DISP;
        end
        else if ((32'(req.priority_level) < 32'(LEVELS)) &&
                 (32'(req.task_handle) < 32'(TASK_SLOTS)))
        begin
            entry_in.op = OP_ENQ;
        end
        else
        begin
            entry_in.op = OP_NOP;
        end
    end

    assign req_stall = (count_reg == CW'(QD));
    assign push      = req_valid && !req_stall;
    assign q_valid   = (count_reg != '0);
    assign q_entry   = q_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QD - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (q_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QD - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !q_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (q_pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= entry_in;
        end
    end

endmodule

// File: design/spmfd_back.sv
module spmfd_back #(
    parameter int LEVELS     = spmfd_pkg::LEVELS_DEF,
    parameter int TASK_SLOTS = spmfd_pkg::TASK_SLOTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  spmfd_pkg::entry_t   q_entry,
    output logic                q_pop,
    output logic                res_valid,
    output spmfd_pkg::rsp_t     res,
    input  logic                res_take
);
    import spmfd_pkg::*;

    // Only levels and handles the command fields can reach get storage.
    localparam int LEV_N  = (LEVELS < (1 << LEVEL_W)) ? LEVELS : (1 << LEVEL_W);
    localparam int SLOT_N = (TASK_SLOTS < (1 << HANDLE_W)) ? TASK_SLOTS : (1 << HANDLE_W);
    localparam int LVW    = $clog2(LEV_N);
    localparam int SW     = $clog2(SLOT_N);

    localparam logic ST_RD = 1'b0;
    localparam logic ST_WR = 1'b1;

    logic                state_reg;
    logic [LEV_N-1:0]    nonempty_reg;
    logic [HANDLE_W-1:0] head_reg [LEV_N];
    logic [HANDLE_W-1:0] tail_reg [LEV_N];
    logic [HANDLE_W-1:0] next_link_reg [SLOT_N];
    logic [HANDLE_W-1:0] link_rd_reg;
    logic [LVW-1:0]      lvl_reg;
    logic [1:0]          op_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic                any_reg;

    logic [LVW-1:0]      top_lvl;
    logic [LVW-1:0]      lvl_sel;
    logic                commit;
    logic                found;
    logic                lvl_busy;
    logic                last_one;

    // Highest non-empty level
    always_comb
    begin
        top_lvl = '0;
        for (int i = 0; i < LEV_N; i++)
        begin
            if (nonempty_reg[i])
            begin
                top_lvl = LVW'(i);
            end
        end
    end

    assign lvl_sel = (q_entry.op == OP_DISP) ? top_lvl : q_entry.level[LVW-1:0];
    assign q_pop   = (state_reg == ST_RD) && q_valid;

    assign res_valid = (state_reg == ST_WR);
    assign commit    = res_valid && res_take;
    assign found     = (op_reg == OP_DISP) && any_reg;
    assign lvl_busy  = nonempty_reg[lvl_reg];
    assign last_one  = (head_reg[lvl_reg] == tail_reg[lvl_reg]);

    assign res.found      = found;
    assign res.out_handle = found ? head_reg[lvl_reg] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_RD;
            nonempty_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_RD:
                begin
                    if (q_pop)
                    begin
                        state_reg <= ST_WR;
                    end
                end
                ST_WR:
                begin
                    if (commit)
                    begin
                        state_reg <= ST_RD;
                        if (op_reg == OP_ENQ)
                        begin
                            nonempty_reg[lvl_reg] <= 1'b1;
                        end
                        else if (found && last_one)
                        begin
                            nonempty_reg[lvl_reg] <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_RD;
                end
            endcase
        end
    end

    // Command capture and head/tail updates
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            lvl_reg    <= lvl_sel;
            op_reg     <= q_entry.op;
            handle_reg <= q_entry.handle;
            any_reg    <= |nonempty_reg;
        end
        if (commit)
        begin
            if (op_reg == OP_ENQ)
            begin
                if (!lvl_busy)
                begin
                    head_reg[lvl_reg] <= handle_reg;
                end
                tail_reg[lvl_reg] <= handle_reg;
            end
            else if (found && !last_one)
            begin
                head_reg[lvl_reg] <= link_rd_reg;
            end
        end
    end

    // Next-link memory: read when a command is popped, written when its result commits
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            link_rd_reg <= next_link_reg[head_reg[lvl_sel][SW-1:0]];
        end
        if (commit && (op_reg == OP_ENQ) && lvl_busy)
        begin
            next_link_reg[tail_reg[lvl_reg][SW-1:0]] <= handle_reg;
        end
    end

`ifndef SYNTHESIS
    a_found_level_live: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && found) |-> lvl_busy)
        else $error("dispatch reports a task from an empty level");

    a_found_is_highest: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && found) |-> (((nonempty_reg >> lvl_reg) >> 1) == '0))
        else $error("dispatch skipped a higher non-empty level");

    a_enq_sets_level: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && (op_reg == OP_ENQ)) |=> nonempty_reg[$past(lvl_reg)])
        else $error("enqueue left its level marked empty");

    a_empty_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && (q_entry.op == OP_DISP) && (nonempty_reg == '0)) |=>
            (res_valid && !res.found))
        else $error("dispatch with all levels empty returned a task");
`endif

endmodule

// File: design/strict_priority_multi_fifo_dispatcher_unit.sv
// Strict-priority dispatcher: one FIFO of task handles per priority level, kept
// as linked lists through a shared next-link memory. A req transfer with
// cmd = enqueue appends task_handle at priority_level; cmd = dispatch pops the
// head of the highest non-empty level. Every req transfer yields exactly one
// rsp transfer, in order: found = 1 with out_handle on a successful dispatch,
// found = 0 and out_handle = 0 otherwise (enqueue, empty dispatch, or an
// enqueue whose level or handle is beyond LEVELS or TASK_SLOTS, which is
// dropped). A handle must not be queued twice at once. Each command passes
// through a read state, which reads the next-link memory (registered read),
// and a write state, which updates head, tail and link state, so the back end
// finishes one command before it takes the next. A 2-entry command queue
// decouples req from the back end, and a response register lets a new command
// be accepted while a result waits on rsp_stall. No memory clear is needed
// after reset; of the list state, only the per-level non-empty bits are reset.
module strict_priority_multi_fifo_dispatcher_unit #(
    parameter int LEVELS     = spmfd_pkg::LEVELS_DEF,
    parameter int TASK_SLOTS = spmfd_pkg::TASK_SLOTS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  spmfd_pkg::req_t  req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output spmfd_pkg::rsp_t  rsp
);
    import spmfd_pkg::*;

    logic    q_valid;
    logic    q_pop;
    entry_t  q_entry;
    logic    res_valid;
    logic    res_take;
    rsp_t    res;
    logic    rsp_valid_reg;
    rsp_t    rsp_reg;

    // Front: classify and queue commands
    spmfd_front #(
        .LEVELS     (LEVELS),
        .TASK_SLOTS (TASK_SLOTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop)
    );

    // Back: list state and the read/update sequence
    spmfd_back #(
        .LEVELS     (LEVELS),
        .TASK_SLOTS (TASK_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take)
    );

    // Response register: takes a new result when empty or being drained.
    assign res_take  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            rsp_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && res_valid)
        begin
            rsp_reg <= res;
        end
    end

endmodule

// File: tb/tb_strict_priority_multi_fifo_dispatcher_unit.sv
`timescale 1ns / 1ps

module tb_strict_priority_multi_fifo_dispatcher_unit;

    import spmfd_pkg::*;

    localparam int NUM_LEVELS = LEVELS_DEF;
    localparam int NUM_SLOTS  = TASK_SLOTS_DEF;

    // No transfer on either channel for this many cycles means the block hung.
    // Worst honest stretch is a long result stall or a long send gap.
    localparam int HANG_LIMIT = 1000;

    // Cycles to keep watching for stray results once nothing is outstanding.
    localparam int SETTLE_CYCLES = 20;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    strict_priority_multi_fifo_dispatcher_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Scheduler shadow: per-level linked lists through a successor table.
    // Head/tail/successor contents only matter once written; busy bits
    // start cleared like the block's non-empty flags.
    // ------------------------------------------------------------------
    logic [HANDLE_W-1:0]   lvl_head [NUM_LEVELS];
    logic [HANDLE_W-1:0]   lvl_tail [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] lvl_busy = '0;
    logic [HANDLE_W-1:0]   succ     [NUM_SLOTS];

    // Results still owed by the block, oldest first.
    rsp_t pending_rsp [$];

    // Which handles sit in some list right now; used to keep random
    // enqueues to handles that are not already queued.
    logic [NUM_SLOTS-1:0] handle_queued = '0;
    int                   queued_count  = 0;

    int  err_count     = 0;
    bit  gaps_enable   = 1'b0;
    bit  stall_enable  = 1'b0;
    int  stall_left    = 0;
    int  idle_cycles   = 0;
    logic [LEVEL_W-1:0] focus_base = '0;

    // Applies one command to the shadow lists and returns the result owed.
    function automatic rsp_t apply_command(req_t r);
        rsp_t res;
        int   lv;
        res = '0;
        if (r.cmd == CMD_ENQUEUE) begin
            lv = int'(r.priority_level);
            if (lv < NUM_LEVELS && int'(r.task_handle) < NUM_SLOTS) begin
                if (!lvl_busy[lv]) begin
                    lvl_head[lv] = r.task_handle;
                    lvl_tail[lv] = r.task_handle;
                    lvl_busy[lv] = 1'b1;
                end
                else begin
                    succ[lvl_tail[lv]] = r.task_handle;
                    lvl_tail[lv]       = r.task_handle;
                end
            end
        end
        else begin
            // Highest busy level wins; its head leaves the list.
            for (lv = NUM_LEVELS - 1; lv >= 0 && !res.found; lv--) begin
                if (lvl_busy[lv]) begin
                    res.found      = 1'b1;
                    res.out_handle = lvl_head[lv];
                    if (lvl_head[lv] == lvl_tail[lv])
                        lvl_busy[lv] = 1'b0;
                    else
                        lvl_head[lv] = succ[lvl_head[lv]];
                end
            end
        end
        return res;
    endfunction

    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("%0t ERROR: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------
    // Result side: check each transfer against the oldest expectation,
    // then decide the stall for the next cycle. Stalls come in bursts,
    // mostly short, now and then long.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
                flag_error($sformatf("result with nothing pending: found=%0d handle=%02h",
                                     rsp.found, rsp.out_handle));
            end
            else begin
                want = pending_rsp.pop_front();
                if (rsp.found !== want.found)
                    flag_error($sformatf("found: expected %0d, got %0d",
                                         want.found, rsp.found));
                if (rsp.out_handle !== want.out_handle)
                    flag_error($sformatf("out_handle: expected %02h, got %02h",
                                         want.out_handle, rsp.out_handle));
            end
        end

        if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
        end
        else if (stall_enable && $urandom_range(0, 99) < 25) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 3);
            stall_left--;
            rsp_stall <= 1'b1;
        end
        else begin
            rsp_stall <= 1'b0;
        end
    end

    // Hang detector: counts cycles without a transfer on either channel.
    always @(posedge clk) begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= HANG_LIMIT) begin
            $display("%0t timeout: no transfer for %0d cycles", $realtime, HANG_LIMIT);
            $display("tb_strict_priority_multi_fifo_dispatcher_unit NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Command side.
    // ------------------------------------------------------------------

    // Presents one command, holds it until the transfer happens, then
    // books the result it owes. req_valid stays high straight into the
    // next command when no gap is drawn.
    task automatic issue_command(input req_t r);
        int   gap;
        rsp_t res;
        gap = 0;
        if (gaps_enable) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: gap = 0;
                6, 7, 8:          gap = $urandom_range(1, 3);
                default:          gap = $urandom_range(8, 30);
            endcase
        end
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);

        res = apply_command(r);
        pending_rsp.push_back(res);
        if (r.cmd == CMD_ENQUEUE) begin
            if (!handle_queued[r.task_handle]) begin
                handle_queued[r.task_handle] = 1'b1;
                queued_count++;
            end
        end
        else if (res.found && handle_queued[res.out_handle]) begin
            handle_queued[res.out_handle] = 1'b0;
            queued_count--;
        end
    endtask

    task automatic enqueue(input logic [HANDLE_W-1:0] h, input logic [LEVEL_W-1:0] lv);
        req_t r;
        r.cmd            = CMD_ENQUEUE;
        r.task_handle    = h;
        r.priority_level = lv;
        issue_command(r);
    endtask

    // Handle and level are don't-care on dispatch, so they carry noise.
    task automatic dispatch();
        req_t r;
        r.cmd            = CMD_DISPATCH;
        r.task_handle    = HANDLE_W'($urandom);
        r.priority_level = LEVEL_W'($urandom);
        issue_command(r);
    endtask

    // Sender holds off until every owed result has come back.
    task automatic wait_drained();
        if (pending_rsp.size() != 0) begin
            req_valid <= 1'b0;
            while (pending_rsp.size() != 0)
                @(posedge clk);
        end
    endtask

    // Random handle that is not in any list yet (caller keeps one free).
    function automatic logic [HANDLE_W-1:0] pick_fresh_handle();
        logic [HANDLE_W-1:0] h;
        do
            h = HANDLE_W'($urandom);
        while (handle_queued[h]);
        return h;
    endfunction

    // Half the picks crowd a few neighboring levels so lists grow long.
    function automatic logic [LEVEL_W-1:0] pick_level();
        if ($urandom_range(0, 1))
            return focus_base + LEVEL_W'($urandom_range(0, 2));
        return LEVEL_W'($urandom);
    endfunction

    // Dispatch everything left, plus one dispatch on the empty scheduler.
    task automatic drain_all();
        while (queued_count > 0 || lvl_busy != '0)
            dispatch();
        dispatch();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_empty_dispatch();
        dispatch();
    endtask

    // Field extremes, FIFO order inside a level, priority across levels.
    task automatic test_priority_order();
        enqueue(8'h00, 4'd0);
        enqueue(8'hFF, 4'd15);
        enqueue(8'hA5, 4'd15);
        enqueue(8'h5A, 4'd7);
        repeat (5) dispatch();
    endtask

    // A handle queued twice: the lists follow the normal update rules.
    task automatic test_duplicate_handle();
        // same level back to back: the link points at itself, one comes out
        enqueue(8'h33, 4'd3);
        enqueue(8'h33, 4'd3);
        dispatch();
        dispatch();
        // same handle on two levels: it comes out of each
        enqueue(8'h44, 4'd1);
        enqueue(8'h44, 4'd9);
        repeat (3) dispatch();
        // requeued behind another handle: tail returns to the head handle
        enqueue(8'h11, 4'd2);
        enqueue(8'h22, 4'd2);
        enqueue(8'h11, 4'd2);
        dispatch();
        dispatch();
        wait_drained();
        handle_queued = '0;
        queued_count  = 0;
    endtask

    // Mixed traffic; dispatches on an empty scheduler act as noise.
    task automatic test_random_mix(input int n_cmds);
        bit do_disp;
        for (int i = 0; i < n_cmds; i++) begin
            if (i % 60 == 0)
                focus_base = LEVEL_W'($urandom);
            if (queued_count == NUM_SLOTS)
                do_disp = 1'b1;
            else if (queued_count == 0)
                do_disp = ($urandom_range(0, 4) == 0);
            else
                do_disp = ($urandom_range(0, 99) < 45);
            if (do_disp)
                dispatch();
            else
                enqueue(pick_fresh_handle(), pick_level());
        end
        drain_all();
    endtask

    // Every handle queued at once, then all dispatched. The fill runs
    // with no idling on either side.
    task automatic test_fill_and_drain();
        gaps_enable  = 1'b0;
        stall_enable = 1'b0;
        focus_base   = LEVEL_W'($urandom);
        while (queued_count < NUM_SLOTS)
            enqueue(pick_fresh_handle(), pick_level());
        gaps_enable  = 1'b1;
        stall_enable = 1'b1;
        drain_all();
    endtask

    // Bursts of enqueues followed by matching dispatches; once the sender
    // pauses until the block has answered everything.
    task automatic test_bursts(input int n_bursts);
        int k;
        for (int b = 0; b < n_bursts; b++) begin
            focus_base = LEVEL_W'($urandom);
            k = $urandom_range(1, 12);
            for (int j = 0; j < k && queued_count < NUM_SLOTS; j++)
                enqueue(pick_fresh_handle(), pick_level());
            if (b == n_bursts / 2)
                wait_drained();
            repeat (k + $urandom_range(0, 2))
                dispatch();
        end
        drain_all();
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_dispatch();
        test_priority_order();
        test_duplicate_handle();

        gaps_enable  = 1'b1;
        stall_enable = 1'b1;
        test_random_mix(330);
        wait_drained();
        test_fill_and_drain();
        wait_drained();
        test_bursts(18);

        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (err_count == 0 && pending_rsp.size() == 0)
            $display("tb_strict_priority_multi_fifo_dispatcher_unit OK");
        else
            $display("tb_strict_priority_multi_fifo_dispatcher_unit NOT OK");
        $finish;
    end

endmodule
